### rtl/core/sobet_pkg.sv
// ----------------------------------------------------------------------------
// sobet_pkg
// Shared widths, reset values, register indexes and helpers for the Sobel
// edge threshold block.
// ----------------------------------------------------------------------------
package sobet_pkg;

  localparam int PIX_W       = 8;
  localparam int COORD_W     = 10;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int SUM_W       = 10;   // c + 2f + i, at most 1020
  localparam int GRAD_W      = 11;   // signed gradient
  localparam int MAG_W       = 10;   // absolute gradient
  localparam int MAN_W       = 11;   // |gx| + |gy|
  localparam int SQ_W        = 22;   // squares and their sum
  localparam int OUT_DATA_W  = 32;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_DIM        = 3;

  localparam logic [CFG_DATA_W-1:0] THR_RESET    = 11'd300;
  localparam logic                  EUC_RESET    = 1'b1;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_EUCLIDEAN = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } cfg_reg_t;

  function automatic logic [MAG_W-1:0] abs_grad(input logic signed [GRAD_W-1:0] v);
    logic signed [GRAD_W-1:0] n;
    n = -v;
    return v[GRAD_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

endpackage

### rtl/core/sobet_ram.sv
// ----------------------------------------------------------------------------
// sobet_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sobet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 Sobel edge detector with a magnitude threshold.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ stream in raster order, one transaction per pixel;
// in_tuser marks the first pixel of a frame and resets the position.
// For every interior pixel one transaction leaves on the out_ stream: 255 for
// an edge, 0 otherwise, with the centre's row and column; out_tlast flags the
// last interior pixel of the frame. Border pixels give no transaction.
// Throughput is one pixel per cycle while out_tready holds: both line buffers
// share one RAM word per column, read when a pixel is taken and written back
// as it leaves stage 1, with forwarding when a write and a read meet on the
// same column. A pixel passes stage 1 (RAM read issued on input, gradients),
// stage 2 (magnitudes), stage 3 (squares) and the output register
// (compare). The stages are elastic; a stalled output holds its transaction
// and keeps taking pixels until the pipeline is full, then in_tready falls.
// Reset (rst_n low, synchronous) clears position, window and pipeline and
// loads the register defaults. Line buffers need no clearing: a frame fills
// them before they are read. The cfg_ port is always ready and must only be
// written while the block is idle.
module sobel_edge_threshold
  import sobet_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input pixel stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_value
  input  logic                  in_tuser,   // [0] frame_start
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] edge_value, [17:8] center_row,
                                            // [27:18] center_col, [31:28] zero
  output logic                  out_tlast,  // frame_last
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WDW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ? $clog2(MAX_WIDTH + 1)
                                                             : CFG_DATA_W;
  localparam int HDW = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ? $clog2(MAX_HEIGHT + 1)
                                                              : CFG_DATA_W;
  localparam int LB_W = 2 * PIX_W;

  // configuration
  logic [CFG_DATA_W-1:0] thr_r, img_w_r, img_h_r;
  logic                  euc_r;
  logic [SQ_W-1:0]       thr_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      euc_r   <= EUC_RESET;
      img_w_r <= WIDTH_RESET;
      img_h_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_addr))
        REG_THRESHOLD: thr_r   <= cfg_data;
        REG_EUCLIDEAN: euc_r   <= cfg_data[0];
        REG_WIDTH:     img_w_r <= cfg_data;
        REG_HEIGHT:    img_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= SQ_W'(thr_r) * SQ_W'(thr_r);
  end

  // clamped frame size, as last index
  logic [WDW-1:0] w_ext, w_cl;
  logic [HDW-1:0] h_ext, h_cl;
  logic [CW-1:0]  w_m1;
  logic [RW-1:0]  h_m1;

  always_comb begin
    w_ext = WDW'(img_w_r);
    h_ext = HDW'(img_h_r);
    if (w_ext < WDW'(MIN_DIM))        w_cl = WDW'(MIN_DIM);
    else if (w_ext > WDW'(MAX_WIDTH)) w_cl = WDW'(MAX_WIDTH);
    else                              w_cl = w_ext;
    if (h_ext < HDW'(MIN_DIM))         h_cl = HDW'(MIN_DIM);
    else if (h_ext > HDW'(MAX_HEIGHT)) h_cl = HDW'(MAX_HEIGHT);
    else                               h_cl = h_ext;
    w_m1 = CW'(w_cl - 1'b1);
    h_m1 = RW'(h_cl - 1'b1);
  end

  // elastic stage handshakes
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic rdy_out, rdy3, rdy2, rdy1;
  logic in_acc, s1_leave;

  assign rdy_out   = !out_v_r || out_tready;
  assign rdy3      = !s3_v_r || rdy_out;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign in_tready = rdy1;
  assign in_acc    = in_tvalid && rdy1;
  assign s1_leave  = s1_v_r && rdy2;

  // position of the incoming pixel
  logic [RW-1:0] row_r, row_now, row_nxt;
  logic [CW-1:0] col_r, col_now, col_nxt;
  logic          prod_now, last_now;

  always_comb begin
    row_now  = in_tuser ? '0 : row_r;
    col_now  = in_tuser ? '0 : col_r;
    prod_now = (row_now >= RW'(2)) && (col_now >= CW'(2));
    last_now = (row_now == h_m1) && (col_now == w_m1);
    if (col_now >= w_m1) begin
      col_nxt = '0;
      row_nxt = (row_now >= h_m1) ? '0 : row_now + 1'b1;
    end else begin
      col_nxt = col_now + 1'b1;
      row_nxt = row_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage 1 registers: pixel and position waiting for the RAM data
  logic [PIX_W-1:0] s1_px_r;
  logic [RW-1:0]    s1_row_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_prod_r, s1_last_r, s1_fwd_r;
  logic [LB_W-1:0]  s1_fwd_data_r;

  // line buffers: [7:0] upper row, [15:8] middle row
  logic [LB_W-1:0] lb_rdata, lb_wdata, lb_word;

  sobet_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_leave),
    .waddr (s1_col_r),
    .wdata (lb_wdata),
    .re    (in_acc),
    .raddr (col_now),
    .rdata (lb_rdata)
  );

  // stage 1: RAM data back, window and gradients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r       <= in_tdata;
      s1_row_r      <= row_now;
      s1_col_r      <= col_now;
      s1_prod_r     <= prod_now;
      s1_last_r     <= last_now;
      // column written back this very cycle: the RAM read would miss it
      s1_fwd_r      <= s1_v_r && (s1_col_r == col_now);
      s1_fwd_data_r <= lb_wdata;
    end
  end

  logic [PIX_W-1:0]         top, mid;
  logic [PIX_W-1:0]         win_r [6];
  logic [SUM_W-1:0]         sum_right, sum_left, sum_bottom, sum_top;
  logic signed [GRAD_W-1:0] gx, gy;

  always_comb begin
    lb_word    = s1_fwd_r ? s1_fwd_data_r : lb_rdata;
    top        = lb_word[PIX_W-1:0];
    mid        = lb_word[LB_W-1:PIX_W];
    lb_wdata   = {s1_px_r, mid};
    sum_right  = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, s1_px_r};
    sum_left   = {2'b00, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b00, win_r[2]};
    sum_bottom = {2'b00, win_r[2]} + {1'b0, win_r[5], 1'b0} + {2'b00, s1_px_r};
    sum_top    = {2'b00, win_r[0]} + {1'b0, win_r[3], 1'b0} + {2'b00, top};
    gx         = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
    gy         = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
  end

  // window: [0..2] two columns back, [3..5] one column back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
    end else if (s1_leave) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_px_r;
    end
  end

  // stage 2: magnitudes
  logic [MAG_W-1:0]   s2_ax_r, s2_ay_r;
  logic [COORD_W-1:0] s2_crow_r, s2_ccol_r;
  logic               s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r && s1_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_ax_r   <= abs_grad(gx);
      s2_ay_r   <= abs_grad(gy);
      s2_crow_r <= COORD_W'(s1_row_r - 1'b1);
      s2_ccol_r <= COORD_W'(s1_col_r - 1'b1);
      s2_last_r <= s1_last_r;
    end
  end

  logic [MAN_W-1:0] man_sum;
  assign man_sum = {1'b0, s2_ax_r} + {1'b0, s2_ay_r};

  // stage 3: squares
  logic [SQ_W-1:0]    s3_sqx_r, s3_sqy_r;
  logic               s3_man_r, s3_last_r;
  logic [COORD_W-1:0] s3_crow_r, s3_ccol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sqx_r  <= SQ_W'(s2_ax_r) * SQ_W'(s2_ax_r);
      s3_sqy_r  <= SQ_W'(s2_ay_r) * SQ_W'(s2_ay_r);
      s3_man_r  <= man_sum > thr_r;
      s3_crow_r <= s2_crow_r;
      s3_ccol_r <= s2_ccol_r;
      s3_last_r <= s2_last_r;
    end
  end

  logic edge_hit;
  assign edge_hit = euc_r ? ((s3_sqx_r + s3_sqy_r) > thr_sq_r) : s3_man_r;

  // output register
  logic [PIX_W-1:0]   out_edge_r;
  logic [COORD_W-1:0] out_crow_r, out_ccol_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_out) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_edge_r <= edge_hit ? EDGE_ON : EDGE_OFF;
      out_crow_r <= s3_crow_r;
      out_ccol_r <= s3_ccol_r;
      out_last_r <= s3_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W - PIX_W - 2 * COORD_W){1'b0}},
                       out_ccol_r, out_crow_r, out_edge_r};
  assign out_tlast  = out_last_r;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the pipeline had room");

  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_crow_r != '0) && (out_ccol_r != '0))
    else $error("result for a border pixel");

  a_edge_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_edge_r == EDGE_ON) || (out_edge_r == EDGE_OFF))
    else $error("edge value neither on nor off");

endmodule
